// ----- rtl/core/hbpf_pkg.sv -----
// Shared types and constants for the handle-bracketed payload finder.
package hbpf_pkg;

   // Fixed field widths
   localparam int BASE_W   = 3;
   localparam int BASES_W  = 63;
   localparam int LEN_W    = 5;
   localparam int LIMIT_W  = 2;
   localparam int POS_W    = 9;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 63;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIVE_BASES = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIVE_LEN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B_BASES    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_B_LEN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_A_BASES    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_A_LEN      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT      = 3'd6;

   // Reset values of the configuration registers
   localparam logic [LEN_W-1:0]   MOTIF_LEN_RESET = 5'd21;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 2'd1;

   // One configured motif as seen by a matcher
   typedef struct packed {
      logic [BASES_W-1:0] bases;
      logic [LEN_W-1:0]   len;
   } motif_cfg_type;

endpackage

// ----- rtl/core/hbpf_motif_match.sv -----
// Approximate motif compare of the newest window bases within a mismatch limit.
module hbpf_motif_match import hbpf_pkg::*; #(
   parameter int MAX_MOTIF_LEN = 21,
   parameter int CNT_W = 10
) (
   input  logic [3*MAX_MOTIF_LEN-1:0] window,
   input  motif_cfg_type              motif,
   input  logic [LIMIT_W-1:0]         limit,
   input  logic [CNT_W-1:0]           count,
   output logic                       hit
);

   localparam int MC_W = $clog2(MAX_MOTIF_LEN + 1);
   localparam int CMP_W = MC_W + LIMIT_W;

   logic                      len_ok;
   logic                      count_ok;
   logic [LEN_W-1:0]          gap;
   logic [LEN_W+1:0]          gap3;
   logic [3*MAX_MOTIF_LEN-1:0] seg;
   logic [MAX_MOTIF_LEN-1:0]  miss;
   logic [MC_W-1:0]           miss_count;

   // Qualify the motif length against the window and the bases seen
   assign len_ok   = (motif.len != '0) && (motif.len <= LEN_W'(MAX_MOTIF_LEN));
   assign count_ok = count >= CNT_W'(motif.len);

   // Align the newest len bases to slot zero
   assign gap  = LEN_W'(MAX_MOTIF_LEN) - motif.len;
   assign gap3 = {1'b0, gap, 1'b0} + {2'b00, gap};
   assign seg  = window >> gap3;

   // Flag a mismatch per motif base
   always_comb begin
      for (int i = 0; i < MAX_MOTIF_LEN; i++) begin
         miss[i] = (LEN_W'(i) < motif.len) &&
                   (seg[3*i +: 3] != motif.bases[3*i +: 3]);
      end
   end

   assign miss_count = MC_W'($countones(miss));
   assign hit = len_ok && count_ok && (CMP_W'(miss_count) <= CMP_W'(limit));

endmodule

// ----- rtl/core/handle_bracketed_payload_finder.sv -----
// Top level: streams read bases, tracks handle matches and emits one result per read.
// Timing: a base is registered at accept; a last base's result is loaded into the
//    result register when that base moves on, and is offered on rsp_ from there.
// Throughput: one base per cycle; the per-read match state is updated in a single
//    pass, and a last base waits only while the previous result is held by rsp_stall.
// Reset: synchronous, active high; clears handshake state, read state and sets the
//    configuration registers to their defaults.
module handle_bracketed_payload_finder import hbpf_pkg::*; #(
   parameter int MAX_READ_LEN = 512,
   parameter int MAX_MOTIF_LEN = 21
) (
   input  logic                  clock,
   input  logic                  reset,
   // Configuration write port
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   // Base stream
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BASE_W-1:0]     req_base_code,
   input  logic                  req_last_base,
   // Result stream
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_payload_valid,
   output logic                  rsp_rule_used,
   output logic [POS_W-1:0]      rsp_payload_offset,
   output logic [POS_W-1:0]      rsp_payload_length,
   output logic                  rsp_read_overflow
);

   localparam int WIN_W = 3 * MAX_MOTIF_LEN;
   localparam int CNT_W = $clog2(MAX_READ_LEN + 2);
   localparam int EW    = CNT_W + 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_READ_LEN);

   // Configuration registers
   motif_cfg_type        five_cfg_ff, b_cfg_ff, a_cfg_ff;
   logic [LIMIT_W-1:0]   limit_ff;

   // Input register
   logic                 in_valid_ff, in_valid_in;
   logic [BASE_W-1:0]    in_code_ff, in_code_in;
   logic                 in_last_ff, in_last_in;

   // Per-read state
   logic [WIN_W-1:0]     window_ff, window_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 five_found_ff, five_found_in;
   logic                 b_found_ff, b_found_in;
   logic                 a_found_ff, a_found_in;
   logic [CNT_W-1:0]     five_start_ff, five_start_in;
   logic [CNT_W-1:0]     b_start_ff, b_start_in;
   logic [CNT_W-1:0]     a_start_ff, a_start_in;

   // Result register
   logic                 out_valid_ff, out_valid_in;
   logic                 out_pvalid_ff, out_pvalid_in;
   logic                 out_rule_ff, out_rule_in;
   logic [POS_W-1:0]     out_start_ff, out_start_in;
   logic [POS_W-1:0]     out_len_ff, out_len_in;
   logic                 out_ovf_ff, out_ovf_in;

   // Working signals
   logic                 advance;
   logic                 accept;
   logic [CNT_W-1:0]     count_new;
   logic                 overflow;
   logic [WIN_W-1:0]     window_shift;
   logic                 five_hit, b_hit, a_hit;
   logic                 five_new, b_new, a_new;
   logic                 five_found_nx, b_found_nx, a_found_nx;
   logic [CNT_W-1:0]     five_start_nx, b_start_nx, a_start_nx;
   logic [EW-1:0]        five_end;
   logic [EW-1:0]        b_start_ext;
   logic [EW-1:0]        gap_len;
   logic [EW+POS_W-1:0]  start_wide;
   logic [EW+POS_W-1:0]  len_wide;

   // Move the held base on unless its result has no room
   assign advance   = in_valid_ff && (!in_last_ff || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // Shift the new base into the top slot
   for (genvar k = 0; k < MAX_MOTIF_LEN; k++) begin : g_slot
      if (k == MAX_MOTIF_LEN - 1) begin : g_top
         assign window_shift[3*k +: 3] = in_code_ff;
      end else begin : g_mid
         assign window_shift[3*k +: 3] = window_ff[3*(k+1) +: 3];
      end
   end

   // Saturating base count; passing the maximum marks overflow
   assign count_new = (count_ff <= CNT_MAX) ? count_ff + 1'b1 : count_ff;
   assign overflow  = count_new > CNT_MAX;

   // Compare the three handles against the updated window
   hbpf_motif_match #(.MAX_MOTIF_LEN(MAX_MOTIF_LEN), .CNT_W(CNT_W)) u_five_match (
      .window(window_shift), .motif(five_cfg_ff), .limit(limit_ff),
      .count(count_new), .hit(five_hit)
   );
   hbpf_motif_match #(.MAX_MOTIF_LEN(MAX_MOTIF_LEN), .CNT_W(CNT_W)) u_b_match (
      .window(window_shift), .motif(b_cfg_ff), .limit(limit_ff),
      .count(count_new), .hit(b_hit)
   );
   hbpf_motif_match #(.MAX_MOTIF_LEN(MAX_MOTIF_LEN), .CNT_W(CNT_W)) u_a_match (
      .window(window_shift), .motif(a_cfg_ff), .limit(limit_ff),
      .count(count_new), .hit(a_hit)
   );

   // Record only the first match of each handle
   assign five_new      = !overflow && !five_found_ff && five_hit;
   assign b_new         = !overflow && !b_found_ff && b_hit;
   assign a_new         = !overflow && !a_found_ff && a_hit;
   assign five_found_nx = five_found_ff || five_new;
   assign b_found_nx    = b_found_ff || b_new;
   assign a_found_nx    = a_found_ff || a_new;
   assign five_start_nx = five_new ? count_new - CNT_W'(five_cfg_ff.len) : five_start_ff;
   assign b_start_nx    = b_new ? count_new - CNT_W'(b_cfg_ff.len) : b_start_ff;
   assign a_start_nx    = a_new ? count_new - CNT_W'(a_cfg_ff.len) : a_start_ff;

   // Bracket geometry from the held five-prime length
   assign five_end    = EW'(five_start_nx) + EW'(five_cfg_ff.len);
   assign b_start_ext = EW'(b_start_nx);
   assign gap_len     = b_start_ext - five_end;

   // Next state of input, read state and result registers
   always_comb begin
      in_valid_in   = in_valid_ff;
      in_code_in    = in_code_ff;
      in_last_in    = in_last_ff;
      window_in     = window_ff;
      count_in      = count_ff;
      five_found_in = five_found_ff;
      b_found_in    = b_found_ff;
      a_found_in    = a_found_ff;
      five_start_in = five_start_ff;
      b_start_in    = b_start_ff;
      a_start_in    = a_start_ff;
      out_valid_in  = out_valid_ff;
      out_pvalid_in = out_pvalid_ff;
      out_rule_in   = out_rule_ff;
      out_start_in  = out_start_ff;
      out_len_in    = out_len_ff;
      out_ovf_in    = out_ovf_ff;
      start_wide    = '0;
      len_wide      = '0;

      // Drop a delivered result
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      // Free or refill the input register
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (accept) begin
         in_valid_in = 1'b1;
         in_code_in  = req_base_code;
         in_last_in  = req_last_base;
      end

      if (advance) begin
         // Update read state
         count_in = count_new;
         if (!overflow) begin
            window_in = window_shift;
         end
         five_found_in = five_found_nx;
         b_found_in    = b_found_nx;
         a_found_in    = a_found_nx;
         five_start_in = five_start_nx;
         b_start_in    = b_start_nx;
         a_start_in    = a_start_nx;

         if (in_last_ff) begin
            // Pick the rule and load the result
            out_valid_in  = 1'b1;
            out_ovf_in    = overflow;
            out_pvalid_in = 1'b0;
            out_rule_in   = 1'b0;
            if (!overflow) begin
               priority if (five_found_nx && b_found_nx && (b_start_ext > five_end)) begin
                  out_pvalid_in = 1'b1;
                  out_rule_in   = 1'b0;
                  start_wide    = {{POS_W{1'b0}}, five_end};
                  len_wide      = {{POS_W{1'b0}}, gap_len};
               end else if (a_found_nx) begin
                  out_pvalid_in = 1'b1;
                  out_rule_in   = 1'b1;
                  len_wide      = {{(POS_W+1){1'b0}}, a_start_nx};
               end else begin
                  out_pvalid_in = 1'b0;
               end
            end
            out_start_in = start_wide[POS_W-1:0];
            out_len_in   = len_wide[POS_W-1:0];

            // Clear read state for the next read
            count_in      = '0;
            five_found_in = 1'b0;
            b_found_in    = 1'b0;
            a_found_in    = 1'b0;
         end
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         five_cfg_ff <= '{bases: '0, len: MOTIF_LEN_RESET};
         b_cfg_ff    <= '{bases: '0, len: MOTIF_LEN_RESET};
         a_cfg_ff    <= '{bases: '0, len: MOTIF_LEN_RESET};
         limit_ff    <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FIVE_BASES: five_cfg_ff.bases <= csr_write_data[BASES_W-1:0];
            CSR_FIVE_LEN:   five_cfg_ff.len   <= csr_write_data[LEN_W-1:0];
            CSR_B_BASES:    b_cfg_ff.bases    <= csr_write_data[BASES_W-1:0];
            CSR_B_LEN:      b_cfg_ff.len      <= csr_write_data[LEN_W-1:0];
            CSR_A_BASES:    a_cfg_ff.bases    <= csr_write_data[BASES_W-1:0];
            CSR_A_LEN:      a_cfg_ff.len      <= csr_write_data[LEN_W-1:0];
            CSR_LIMIT:      limit_ff          <= csr_write_data[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         count_ff      <= '0;
         five_found_ff <= 1'b0;
         b_found_ff    <= 1'b0;
         a_found_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         count_ff      <= count_in;
         five_found_ff <= five_found_in;
         b_found_ff    <= b_found_in;
         a_found_ff    <= a_found_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_code_ff    <= in_code_in;
      in_last_ff    <= in_last_in;
      window_ff     <= window_in;
      five_start_ff <= five_start_in;
      b_start_ff    <= b_start_in;
      a_start_ff    <= a_start_in;
      out_pvalid_ff <= out_pvalid_in;
      out_rule_ff   <= out_rule_in;
      out_start_ff  <= out_start_in;
      out_len_ff    <= out_len_in;
      out_ovf_ff    <= out_ovf_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_payload_valid  = out_pvalid_ff;
   assign rsp_rule_used      = out_rule_ff;
   assign rsp_payload_offset = out_start_ff;
   assign rsp_payload_length = out_len_ff;
   assign rsp_read_overflow  = out_ovf_ff;

   // An overflowed read never reports a payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_overflow |-> !rsp_payload_valid)
      else $error("overflowed read reported a payload");

   // An invalid result carries zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_valid |->
         !rsp_rule_used && (rsp_payload_offset == '0) && (rsp_payload_length == '0))
      else $error("invalid result with nonzero fields");

   // Stall only while a held base cannot move on
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && in_last_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   // Base count never runs past its saturation point
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX + 1'b1)
      else $error("base count beyond saturation");

   // The prefix rule starts at the first base
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_valid && rsp_rule_used |-> rsp_payload_offset == '0)
      else $error("prefix payload not at read start");

endmodule

// ----- sim/handle_bracketed_payload_finder_test.sv -----
// Self-checking testbench for the handle-bracketed payload finder.

// One read result as the block reports it
typedef struct packed {
   logic                       payload_valid;
   logic                       rule_used;
   logic [hbpf_pkg::POS_W-1:0] payload_offset;
   logic [hbpf_pkg::POS_W-1:0] payload_length;
   logic                       read_overflow;
} read_result_type;

typedef enum int {FIVE_HANDLE = 0, B_HANDLE = 1, A_HANDLE = 2} handle_type;

localparam logic RULE_BRACKETED = 1'b0;
localparam logic RULE_PREFIX    = 1'b1;

// Tracks handle matches per read and holds the payload results still owed by the block
class read_payload_checker #(int READ_MAX = 512, int MOTIF_MAX = 21);
   logic [hbpf_pkg::BASES_W-1:0] motif_bases [3];
   logic [hbpf_pkg::LEN_W-1:0]   motif_len [3];
   logic [hbpf_pkg::LIMIT_W-1:0] mismatch_limit;

   logic [3*MOTIF_MAX-1:0] window;
   int unsigned            count;
   bit                     found [3];
   int unsigned            start_pos [3];

   read_result_type expected_payloads [$];
   int unsigned     failures;

   function new();
      int h;
      for (h = 0; h < 3; h++) begin
         motif_bases[h] = '0;
         motif_len[h] = hbpf_pkg::MOTIF_LEN_RESET;
      end
      mismatch_limit = hbpf_pkg::LIMIT_RESET;
      failures = 0;
      clear_read();
   endfunction

   function void clear_read();
      int h;
      window = '0;
      count = 0;
      for (h = 0; h < 3; h++) begin
         found[h] = 1'b0;
         start_pos[h] = 0;
      end
   endfunction

   // Mirror a register write
   function void set_register(logic [hbpf_pkg::CSR_IDX_W-1:0] idx,
                              logic [hbpf_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         hbpf_pkg::CSR_FIVE_BASES: motif_bases[FIVE_HANDLE] = data;
         hbpf_pkg::CSR_FIVE_LEN:   motif_len[FIVE_HANDLE] = data[hbpf_pkg::LEN_W-1:0];
         hbpf_pkg::CSR_B_BASES:    motif_bases[B_HANDLE] = data;
         hbpf_pkg::CSR_B_LEN:      motif_len[B_HANDLE] = data[hbpf_pkg::LEN_W-1:0];
         hbpf_pkg::CSR_A_BASES:    motif_bases[A_HANDLE] = data;
         hbpf_pkg::CSR_A_LEN:      motif_len[A_HANDLE] = data[hbpf_pkg::LEN_W-1:0];
         hbpf_pkg::CSR_LIMIT:      mismatch_limit = data[hbpf_pkg::LIMIT_W-1:0];
         default: ;
      endcase
   endfunction

   // Compare a handle against the newest bases of the window
   function bit motif_hit(int h);
      logic [3*MOTIF_MAX-1:0] seg;
      int unsigned len, miss, i;
      len = motif_len[h];
      if (len == 0 || len > MOTIF_MAX || count < len)
         return 1'b0;
      seg = window >> (3 * (MOTIF_MAX - len));
      miss = 0;
      for (i = 0; i < len; i++) begin
         if (seg[3*i +: 3] != motif_bases[h][3*i +: 3])
            miss++;
      end
      return miss <= mismatch_limit;
   endfunction

   // Advance the read state by one accepted base; queue a result at the read's end
   function void note_base(logic [hbpf_pkg::BASE_W-1:0] code, logic last);
      read_result_type r;
      bit overflow;
      int unsigned five_end, span;
      int h;
      if (count <= READ_MAX)
         count++;
      overflow = count > READ_MAX;
      if (!overflow) begin
         window = (window >> 3) | ((3*MOTIF_MAX)'(code) << (3 * (MOTIF_MAX - 1)));
         for (h = 0; h < 3; h++) begin
            if (!found[h] && motif_hit(h)) begin
               found[h] = 1'b1;
               start_pos[h] = count - motif_len[h];
            end
         end
      end
      if (!last)
         return;
      r = '0;
      r.read_overflow = overflow;
      if (!overflow) begin
         five_end = start_pos[FIVE_HANDLE] + motif_len[FIVE_HANDLE];
         if (found[FIVE_HANDLE] && found[B_HANDLE] && start_pos[B_HANDLE] > five_end) begin
            span = start_pos[B_HANDLE] - five_end;
            r.payload_valid = 1'b1;
            r.rule_used = RULE_BRACKETED;
            r.payload_offset = five_end[hbpf_pkg::POS_W-1:0];
            r.payload_length = span[hbpf_pkg::POS_W-1:0];
         end else if (found[A_HANDLE]) begin
            r.payload_valid = 1'b1;
            r.rule_used = RULE_PREFIX;
            r.payload_length = start_pos[A_HANDLE][hbpf_pkg::POS_W-1:0];
         end
      end
      expected_payloads.push_back(r);
      clear_read();
   endfunction

   function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         failures++;
      end
   endfunction

   // Match a reported result against the oldest one owed
   function void check_result(read_result_type got);
      read_result_type want;
      if (expected_payloads.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %h", $time, got);
         failures++;
         return;
      end
      want = expected_payloads.pop_front();
      compare_field("payload_valid", want.payload_valid, got.payload_valid);
      compare_field("rule_used", want.rule_used, got.rule_used);
      compare_field("payload_offset", want.payload_offset, got.payload_offset);
      compare_field("payload_length", want.payload_length, got.payload_length);
      compare_field("read_overflow", want.read_overflow, got.read_overflow);
   endfunction

   function int pending();
      return expected_payloads.size();
   endfunction
endclass

module handle_bracketed_payload_finder_test import hbpf_pkg::*; ();

   localparam int READ_MAX    = 512;
   localparam int MOTIF_MAX   = 21;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 50;
   localparam int LONG_PHASE  = 3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BASE_W-1:0]     req_base_code = '0;
   logic                  req_last_base = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_payload_valid;
   logic                  rsp_rule_used;
   logic [POS_W-1:0]      rsp_payload_offset;
   logic [POS_W-1:0]      rsp_payload_length;
   logic                  rsp_read_overflow;

   read_payload_checker #(READ_MAX, MOTIF_MAX) sb;
   logic [BASE_W-1:0] read_bases [$];
   bit quiet = 1'b0;
   int stall_left = 0;

   handle_bracketed_payload_finder #(
      .MAX_READ_LEN(READ_MAX),
      .MAX_MOTIF_LEN(MOTIF_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_base_code(req_base_code),
      .req_last_base(req_last_base),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload_valid(rsp_payload_valid),
      .rsp_rule_used(rsp_rule_used),
      .rsp_payload_offset(rsp_payload_offset),
      .rsp_payload_length(rsp_payload_length),
      .rsp_read_overflow(rsp_read_overflow)
   );

   always #5 clock = ~clock;

   // Stall the result side in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 19) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check each result transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_payload_valid, rsp_rule_used, rsp_payload_offset,
                          rsp_payload_length, rsp_read_overflow});
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      sb.set_register(idx, data);
   endtask

   // Hold a base until the block takes it
   task automatic send_base(input logic [BASE_W-1:0] code, input logic last);
      req_valid <= 1'b1;
      req_base_code <= code;
      req_last_base <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_base(code, last);
   endtask

   task automatic send_read();
      int n, i;
      n = read_bases.size();
      for (i = 0; i < n; i++) begin
         if (!quiet && $urandom_range(0, 7) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         send_base(read_bases[i], i == n - 1);
      end
   endtask

   // Drop valid and let every owed result come back
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void add_random(input int n);
      repeat (n) read_bases.push_back(BASE_W'($urandom_range(0, 7)));
   endfunction

   // Append a handle, sometimes with a few substituted bases
   function automatic void add_motif(input handle_type h);
      int len, first, flips, i;
      len = sb.motif_len[h];
      if (len == 0 || len > MOTIF_MAX) begin
         add_random($urandom_range(1, MOTIF_MAX));
         return;
      end
      first = read_bases.size();
      for (i = 0; i < len; i++)
         read_bases.push_back(sb.motif_bases[h][3*i +: 3]);
      flips = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, sb.mismatch_limit + 1);
      repeat (flips)
         read_bases[first + $urandom_range(0, len - 1)] = BASE_W'($urandom_range(0, 7));
   endfunction

   // Build one read: mostly handle-bracketed, then prefix, out of order and noise
   function automatic void make_read();
      int kind;
      read_bases.delete();
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
         add_random($urandom_range(0, 8));
         add_motif(FIVE_HANDLE);
         add_random($urandom_range(0, 24));
         add_motif(B_HANDLE);
         if ($urandom_range(0, 3) == 0)
            add_motif(A_HANDLE);
         add_random($urandom_range(0, 4));
      end else if (kind <= 7) begin
         add_random($urandom_range(0, 30));
         add_motif(A_HANDLE);
         add_random($urandom_range(0, 6));
      end else if (kind == 8) begin
         add_random($urandom_range(0, 4));
         add_motif(B_HANDLE);
         add_random($urandom_range(0, 6));
         add_motif(FIVE_HANDLE);
         if ($urandom_range(0, 1) == 0)
            add_motif(A_HANDLE);
      end else begin
         add_random($urandom_range(1, 40));
      end
      if (read_bases.size() == 0)
         add_random(1);
   endfunction

   function automatic logic [BASES_W-1:0] pick_bases();
      logic [BASES_W-1:0] v;
      int r, i;
      r = $urandom_range(0, 7);
      v = '0;
      if (r == 0) begin
         v = '1;
      end else if (r <= 4) begin
         for (i = 0; i < MOTIF_MAX; i++)
            v[3*i +: 3] = BASE_W'($urandom_range(0, 3));
      end else if (r != 1) begin
         v = BASES_W'({$urandom, $urandom});
      end
      return v;
   endfunction

   function automatic logic [LEN_W-1:0] pick_len();
      int r;
      r = $urandom_range(0, 15);
      case (r)
         0: return '0;
         1: return LEN_W'($urandom_range(MOTIF_MAX + 1, 31));
         2: return LEN_W'(MOTIF_MAX);
         3: return LEN_W'(1);
         default: return LEN_W'($urandom_range(2, 12));
      endcase
   endfunction

   // Program all registers for one phase; junk in the unused upper bits
   task automatic program_phase(input int phase);
      logic [BASES_W-1:0]    bases [3];
      logic [LEN_W-1:0]      lens [3];
      logic [LIMIT_W-1:0]    limit_val;
      logic [CSR_DATA_W-1:0] pad;
      int h;
      for (h = 0; h < 3; h++) begin
         bases[h] = pick_bases();
         lens[h] = pick_len();
      end
      limit_val = LIMIT_W'($urandom_range(0, 3));
      case (phase)
         1: begin
            limit_val = '0;
            bases[FIVE_HANDLE] = '1;
            for (h = 0; h < 3; h++)
               lens[h] = LEN_W'(MOTIF_MAX);
         end
         2: begin
            limit_val = '1;
            lens[FIVE_HANDLE] = LEN_W'(1);
            lens[B_HANDLE] = LEN_W'(MOTIF_MAX);
            lens[A_HANDLE] = '0;
         end
         LONG_PHASE: begin
            limit_val = LIMIT_W'(1);
            for (h = 0; h < 3; h++)
               lens[h] = LEN_W'($urandom_range(4, MOTIF_MAX));
         end
         default: ;
      endcase
      pad = CSR_DATA_W'({$urandom, $urandom});
      write_reg(CSR_FIVE_BASES, bases[FIVE_HANDLE]);
      write_reg(CSR_FIVE_LEN, {pad[CSR_DATA_W-1:LEN_W], lens[FIVE_HANDLE]});
      write_reg(CSR_B_BASES, bases[B_HANDLE]);
      write_reg(CSR_B_LEN, {pad[CSR_DATA_W-1:LEN_W], lens[B_HANDLE]});
      write_reg(CSR_A_BASES, bases[A_HANDLE]);
      write_reg(CSR_A_LEN, {pad[CSR_DATA_W-1:LEN_W], lens[A_HANDLE]});
      write_reg(CSR_LIMIT, {pad[CSR_DATA_W-1:LIMIT_W], limit_val});
   endtask

   initial begin
      int phase, sent, k;
      int targets [3];
      bit front;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Two-base handles, exact match only
      write_reg(CSR_FIVE_BASES, CSR_DATA_W'(17));
      write_reg(CSR_FIVE_LEN, CSR_DATA_W'(2));
      write_reg(CSR_B_BASES, CSR_DATA_W'(27));
      write_reg(CSR_B_LEN, CSR_DATA_W'(2));
      write_reg(CSR_A_BASES, CSR_DATA_W'(44));
      write_reg(CSR_A_LEN, CSR_DATA_W'(2));
      write_reg(CSR_LIMIT, CSR_DATA_W'(0));

      // Bracketed payload of two bases
      read_bases = {3'd1, 3'd2, 3'd7, 3'd6, 3'd3, 3'd3};
      send_read();
      // Handles touching: fall back to an empty prefix
      read_bases = {3'd4, 3'd5, 3'd1, 3'd2, 3'd3, 3'd3};
      send_read();
      // One-base read, shorter than any handle
      read_bases = {3'd0};
      send_read();
      // B handle before the five-prime handle: prefix rule
      read_bases = {3'd3, 3'd3, 3'd0, 3'd1, 3'd2, 3'd4, 3'd5};
      send_read();

      for (phase = 1; phase < PHASES; phase++) begin
         settle();
         quiet = (phase == PHASES - 1);
         program_phase(phase);
         if (phase == LONG_PHASE) begin
            // Longest legal read, then overflowing ones
            targets[0] = READ_MAX;
            targets[1] = READ_MAX + 1;
            targets[2] = $urandom_range(READ_MAX + 2, READ_MAX + 28);
            for (k = 0; k < 3; k++) begin
               make_read();
               front = (k == 0) || ($urandom_range(0, 1) == 1);
               while (read_bases.size() < targets[k]) begin
                  if (front)
                     read_bases.push_front(BASE_W'($urandom_range(0, 7)));
                  else
                     read_bases.push_back(BASE_W'($urandom_range(0, 7)));
               end
               send_read();
            end
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            make_read();
            sent += read_bases.size();
            send_read();
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (sb.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
